>>> rtl/core/aabb_pcr_pkg.sv
// Package with the request and result types of the box pair collision resolver.
`default_nettype none

package aabb_pcr_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HalfW  = 30;
  localparam int unsigned SumW   = HalfW + 1;
  localparam int unsigned DiffW  = CoordW + 1;

  localparam logic CmdFirst  = 1'b0;
  localparam logic CmdSecond = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [HalfW-1:0]         half_x;
    logic [HalfW-1:0]         half_y;
    logic [HalfW-1:0]         half_z;
    logic                     movable;
  } in_item_t;

  typedef struct packed {
    logic                     collided;
    logic signed [CoordW-1:0] move_first_x;
    logic signed [CoordW-1:0] move_first_y;
    logic signed [CoordW-1:0] move_first_z;
    logic signed [CoordW-1:0] move_second_x;
    logic signed [CoordW-1:0] move_second_y;
    logic signed [CoordW-1:0] move_second_z;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/aabb_pair_collision_resolve.sv
// Top level of the axis-aligned box pair collision resolver.
//
// Boxes arrive on the in_ channel as requests: a request with cmd 0 stores the
// first box of a pair and produces no result, a request with cmd 1 tests the
// second box against the stored one and produces exactly one result on the
// out_ channel. A request is accepted when in_valid is high and in_stall low.
// The result carries a collided flag and the displacement of each box along
// the axis of smallest penetration.
// A second-box request reaches out_valid through the registers in turn: the
// center differences and extent sums are registered as it is accepted, then the
// penetrations, and then the chosen axis with the split push in the output
// register.
// One request is accepted every cycle while the output is taken.
// When the receiver raises out_stall the result holds in the output register,
// the two inner stages keep filling, and in_stall rises once they are full.
// A synchronous reset empties the pipeline and clears the stored box to zero,
// so a second box that arrives first is tested against an all-zero box.
`default_nettype none

module aabb_pair_collision_resolve (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire aabb_pcr_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output aabb_pcr_pkg::out_item_t out_data
);

  localparam int unsigned CW = aabb_pcr_pkg::CoordW;
  localparam int unsigned HW = aabb_pcr_pkg::HalfW;
  localparam int unsigned SW = aabb_pcr_pkg::SumW;
  localparam int unsigned DW = aabb_pcr_pkg::DiffW;

  logic signed [CW-1:0] held_c_r [3];
  logic [HW-1:0]        held_h_r [3];
  logic                 held_mov_r;

  logic                 s1_v_r;
  logic signed [DW-1:0] s1_d_r [3];
  logic [SW-1:0]        s1_s_r [3];
  logic                 s1_mov1_r;
  logic                 s1_mov2_r;

  logic                 s2_v_r;
  logic [SW-1:0]        s2_pen_r [3];
  logic                 s2_neg_r [3];
  logic                 s2_hit_r;
  logic                 s2_mov1_r;
  logic                 s2_mov2_r;

  logic                      out_v_r;
  aabb_pcr_pkg::out_item_t   out_r;

  logic out_ready, s2_ready, s1_ready;
  logic in_fire, first_fire, second_fire;

  logic signed [CW-1:0] in_c [3];
  logic [HW-1:0]        in_h [3];

  assign out_ready   = !out_v_r || !out_stall;
  assign s2_ready    = !s2_v_r || out_ready;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_stall    = !s1_ready;
  assign in_fire     = in_valid && s1_ready;
  assign first_fire  = in_fire && (in_data.cmd == aabb_pcr_pkg::CmdFirst);
  assign second_fire = in_fire && (in_data.cmd == aabb_pcr_pkg::CmdSecond);

  assign in_c[0] = in_data.center_x;
  assign in_c[1] = in_data.center_y;
  assign in_c[2] = in_data.center_z;
  assign in_h[0] = in_data.half_x;
  assign in_h[1] = in_data.half_y;
  assign in_h[2] = in_data.half_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        held_c_r[i] <= '0;
        held_h_r[i] <= '0;
      end
      held_mov_r <= 1'b0;
    end else if (first_fire) begin
      for (int i = 0; i < 3; i++) begin
        held_c_r[i] <= in_c[i];
        held_h_r[i] <= in_h[i];
      end
      held_mov_r <= in_data.movable;
    end
  end

  // Stage 1: center difference and extent sum per axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= second_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (second_fire) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i] <= DW'(held_c_r[i]) - DW'(in_c[i]);
        s1_s_r[i] <= SW'(held_h_r[i]) + SW'(in_h[i]);
      end
      s1_mov1_r <= held_mov_r;
      s1_mov2_r <= in_data.movable;
    end
  end

  // Stage 2: penetration depth and overlap test per axis.
  logic [CW-1:0] mag [3];
  logic [DW-1:0] gap [3];
  logic          axis_hit [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]      = s1_d_r[i][DW-1] ? CW'(-s1_d_r[i]) : CW'(s1_d_r[i]);
      gap[i]      = DW'(s1_s_r[i]) - DW'(mag[i]);
      axis_hit[i] = !gap[i][DW-1] && (gap[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        s2_pen_r[i] <= gap[i][SW-1:0];
        s2_neg_r[i] <= s1_d_r[i][DW-1];
      end
      s2_hit_r  <= axis_hit[0] && axis_hit[1] && axis_hit[2] &&
                   (s1_mov1_r || s1_mov2_r);
      s2_mov1_r <= s1_mov1_r;
      s2_mov2_r <= s1_mov2_r;
    end
  end

  // Stage 3: smallest axis, signed push and its split between the boxes.
  aabb_pcr_pkg::axis_t     keep;
  logic [SW-1:0]           pen_k;
  logic                    neg_k;
  logic signed [CW-1:0]    push;
  logic signed [CW-1:0]    half_push;
  logic signed [CW-1:0]    mv1;
  logic signed [CW-1:0]    mv2;
  aabb_pcr_pkg::out_item_t out_nxt;

  always_comb begin
    if (s2_pen_r[0] < s2_pen_r[1]) begin
      keep = (s2_pen_r[2] < s2_pen_r[0]) ? aabb_pcr_pkg::AXIS_Z : aabb_pcr_pkg::AXIS_X;
    end else begin
      keep = (s2_pen_r[2] < s2_pen_r[1]) ? aabb_pcr_pkg::AXIS_Z : aabb_pcr_pkg::AXIS_Y;
    end

    case (keep)
      aabb_pcr_pkg::AXIS_X: begin
        pen_k = s2_pen_r[0];
        neg_k = s2_neg_r[0];
      end
      aabb_pcr_pkg::AXIS_Y: begin
        pen_k = s2_pen_r[1];
        neg_k = s2_neg_r[1];
      end
      aabb_pcr_pkg::AXIS_Z: begin
        pen_k = s2_pen_r[2];
        neg_k = s2_neg_r[2];
      end
      default: begin
        pen_k = '0;
        neg_k = 1'b0;
      end
    endcase

    push      = neg_k ? -CW'(pen_k) : CW'(pen_k);
    half_push = push >>> 1;

    if (!s2_hit_r) begin
      mv1 = '0;
      mv2 = '0;
    end else if (s2_mov1_r && s2_mov2_r) begin
      mv1 = half_push;
      mv2 = half_push - push;
    end else if (s2_mov1_r) begin
      mv1 = push;
      mv2 = '0;
    end else begin
      mv1 = '0;
      mv2 = -push;
    end

    out_nxt               = '0;
    out_nxt.collided      = s2_hit_r;
    out_nxt.move_first_x  = (keep == aabb_pcr_pkg::AXIS_X) ? mv1 : '0;
    out_nxt.move_first_y  = (keep == aabb_pcr_pkg::AXIS_Y) ? mv1 : '0;
    out_nxt.move_first_z  = (keep == aabb_pcr_pkg::AXIS_Z) ? mv1 : '0;
    out_nxt.move_second_x = (keep == aabb_pcr_pkg::AXIS_X) ? mv2 : '0;
    out_nxt.move_second_y = (keep == aabb_pcr_pkg::AXIS_Y) ? mv2 : '0;
    out_nxt.move_second_z = (keep == aabb_pcr_pkg::AXIS_Z) ? mv2 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_second_enters: assert property (@(posedge clk) disable iff (!rst_n)
    second_fire |=> s1_v_r)
    else $error("Accepted second box did not enter the pipeline.");

  a_first_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (first_fire && !s1_v_r) |=> !s1_v_r)
    else $error("First box request started a result.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.collided) |->
      (out_r.move_first_x == '0 && out_r.move_first_y == '0 &&
       out_r.move_first_z == '0 && out_r.move_second_x == '0 &&
       out_r.move_second_y == '0 && out_r.move_second_z == '0))
    else $error("Result without collision carries a displacement.");

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |->
      $onehot0({(out_r.move_first_x != '0) || (out_r.move_second_x != '0),
                (out_r.move_first_y != '0) || (out_r.move_second_y != '0),
                (out_r.move_first_z != '0) || (out_r.move_second_z != '0)}))
    else $error("Displacement spans more than one axis.");

  a_push_separates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.collided) |->
      ((out_r.move_first_x != out_r.move_second_x) ||
       (out_r.move_first_y != out_r.move_second_y) ||
       (out_r.move_first_z != out_r.move_second_z)))
    else $error("Collision result does not separate the boxes.");

endmodule

`default_nettype wire
